>>> rtl/core/sos_pkg.sv
`timescale 1ns / 1ps

package sos_pkg;

   localparam int DIST_W  = 16;
   localparam int INDEX_W = 8;
   localparam int SPAN_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int BINS_DEFAULT = 180;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR_LIMIT = 2'd0,
      CSR_JUMP_LIMIT = 2'd1,
      CSR_MIN_SPAN   = 2'd2
   } csr_index_type;

   localparam logic [DIST_W-1:0] NEAR_LIMIT_RESET = 16'd5000;
   localparam logic [DIST_W-1:0] JUMP_LIMIT_RESET = 16'd150;
   localparam logic [SPAN_W-1:0] MIN_SPAN_RESET   = 8'd3;

   typedef struct packed {
      logic [DIST_W-1:0] near_limit_mm;
      logic [DIST_W-1:0] jump_limit_mm;
      logic [SPAN_W-1:0] min_span;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_W-1:0] bin_index;
      logic [DIST_W-1:0]  previous_distance;
      logic [INDEX_W-1:0] run_start;
      logic               in_run;
   } scan_state_type;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] span_start;
      logic [INDEX_W-1:0] span_end;
   } span_type;

   // A run is reported when it is ordered and long enough.
   function automatic logic span_long_enough(input logic [INDEX_W-1:0] first,
                                             input logic [INDEX_W-1:0] last,
                                             input logic [SPAN_W-1:0]  min_span);
      logic [INDEX_W-1:0] len;
      len = last - first;
      return (last >= first) && (len >= min_span);
   endfunction

endpackage

>>> rtl/core/scan_obstacle_span_segmenter.sv
`timescale 1ns / 1ps

// Obstacle span segmenter: takes one range reading per angular bin, in scan
// order, counting bins 0..BINS-1 itself, and reports each run of near bins
// (no neighbor jump at or above the jump limit) whose end minus start reaches
// the minimum span. One bin is taken every cycle; the compare and subtract on
// a bin and the state update finish in that cycle, and a span appears in the
// output register in the cycle after the bin that closes it. The input stalls
// only while a span waits in the output register and rsp_ready is low.
// Registers: 0 near limit, 1 jump limit, 2 minimum span; write while idle.

module scan_obstacle_span_segmenter
   import sos_pkg::*;
#(
   parameter int BINS = BINS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DIST_W-1:0]     req_distance_mm,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [INDEX_W-1:0]    rsp_span_start,
   output logic [INDEX_W-1:0]    rsp_span_end,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type        cfg;
   scan_state_type state_ff;
   scan_state_type state_in;
   span_type       span;
   logic           req_xfer;

   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] span_start_ff;
   logic [INDEX_W-1:0] span_end_ff;

   sos_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wr_data),
      .cfg      (cfg)
   );

   sos_step #(.BINS(BINS)) u_step (
      .distance_mm (req_distance_mm),
      .cfg         (cfg),
      .state       (state_ff),
      .state_in    (state_in),
      .span        (span)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         if (req_xfer && span.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && span.valid) begin
         span_start_ff <= span.span_start;
         span_end_ff   <= span.span_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_start = span_start_ff;
   assign rsp_span_end   = span_end_ff;

endmodule

>>> rtl/core/sos_csr.sv
`timescale 1ns / 1ps

module sos_csr
   import sos_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit_mm <= NEAR_LIMIT_RESET;
         cfg_ff.jump_limit_mm <= JUMP_LIMIT_RESET;
         cfg_ff.min_span      <= MIN_SPAN_RESET;
      end else if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_NEAR_LIMIT: cfg_ff.near_limit_mm <= wr_data;
            CSR_JUMP_LIMIT: cfg_ff.jump_limit_mm <= wr_data;
            CSR_MIN_SPAN:   cfg_ff.min_span      <= wr_data[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/sos_step.sv
`timescale 1ns / 1ps

module sos_step
   import sos_pkg::*;
#(
   parameter int BINS = BINS_DEFAULT
)
(
   input  logic [DIST_W-1:0] distance_mm,
   input  cfg_type           cfg,
   input  scan_state_type    state,
   output scan_state_type    state_in,
   output span_type          span
);

   localparam logic [INDEX_W-1:0] LAST_BIN = INDEX_W'(BINS - 1);

   logic               near;
   logic               last;
   logic [DIST_W-1:0]  diff;
   logic               cont;
   logic               brk;
   logic               open_after;
   logic [INDEX_W-1:0] start_after;
   logic [INDEX_W-1:0] prev_bin;

   always_comb begin
      near     = distance_mm < cfg.near_limit_mm;
      last     = state.bin_index >= LAST_BIN;
      diff     = (distance_mm >= state.previous_distance)
                 ? distance_mm - state.previous_distance
                 : state.previous_distance - distance_mm;
      cont     = near && (diff < cfg.jump_limit_mm);
      brk      = state.in_run && !cont;
      prev_bin = state.bin_index - INDEX_W'(1);

      open_after  = state.in_run ? cont : near;
      start_after = (!state.in_run && near) ? state.bin_index : state.run_start;

      span.valid      = 1'b0;
      span.span_start = start_after;
      span.span_end   = prev_bin;
      if (brk) begin
         span.valid = span_long_enough(state.run_start, prev_bin, cfg.min_span);
      end
      // flush of a run still open at the end of the scan
      if (last && open_after) begin
         span.span_end = state.bin_index;
         span.valid    = span_long_enough(start_after, state.bin_index, cfg.min_span);
      end

      state_in.bin_index         = last ? '0 : state.bin_index + INDEX_W'(1);
      state_in.previous_distance = distance_mm;
      state_in.run_start         = start_after;
      state_in.in_run            = open_after && !last;
   end

endmodule

>>> rtl/core/sos_checker.sv
`timescale 1ns / 1ps

module sos_checker
   import sos_pkg::*;
#(
   parameter int BINS = BINS_DEFAULT
)
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [INDEX_W-1:0] rsp_span_start,
   input logic [INDEX_W-1:0] rsp_span_end
);

   localparam logic [INDEX_W-1:0] LAST_BIN = INDEX_W'(BINS - 1);

   // a held result keeps its payload until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_span_start)
                                  && $stable(rsp_span_end))
      else $error("result dropped or changed while stalled");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_span_end >= rsp_span_start && rsp_span_end <= LAST_BIN)
      else $error("reported span out of order or beyond the scan");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   a_stall_on_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result blocked");

   a_no_span_without_bin: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(req_valid && req_ready))
      else $error("span appeared without an input transfer");

endmodule

bind scan_obstacle_span_segmenter sos_checker #(.BINS(BINS)) u_sos_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_span_start (rsp_span_start),
   .rsp_span_end   (rsp_span_end)
);
